// ===== hdl/ifp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types and constants of the IMU angle frame parser: the input and
// result beat layouts, frame geometry and register indexes.
// ----------------------------------------------------------------------------
package ifp_pkg;

  // frame geometry
  localparam int unsigned FrameLen = 11;
  localparam int unsigned HdrLen   = 2;
  localparam int unsigned DataLen  = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned DataIdxW = $clog2(DataLen);

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgIdxSync = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxType = CfgIdxW'(1);

  // register reset values
  localparam logic [7:0] SyncByteRst = 8'h55;
  localparam logic [7:0] TypeByteRst = 8'h53;

  // one received serial byte and its result-pending flag
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       result_pending;
  } in_beat_t;

  // one decoded angle frame
  typedef struct packed {
    logic signed [15:0] roll_code;
    logic signed [15:0] pitch_code;
    logic signed [15:0] yaw_code;
    logic        [15:0] extra_word;
  } out_beat_t;

endpackage

// ===== hdl/ifp_in_stage.sv =====
// ----------------------------------------------------------------------------
// ifp_in_stage
// Input register: holds one accepted byte beat until the parser consumes it.
// ----------------------------------------------------------------------------
module ifp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ifp_pkg::in_beat_t in_data_i,
  input  logic             adv_i,
  output logic             beat_valid_o,
  output ifp_pkg::in_beat_t beat_o
);
  import ifp_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t data_q;
  logic     accept;

  // free when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = data_q;

endmodule

// ===== hdl/ifp_parser.sv =====
// ----------------------------------------------------------------------------
// ifp_parser
// Frame state machine: hunts sync and type, collects data and checksum, and
// judges the frame on the following byte. Also holds the header registers.
// ----------------------------------------------------------------------------
module ifp_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [ifp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ifp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           beat_valid_i,
  input  ifp_pkg::in_beat_t              beat_i,
  input  logic                           out_free_i,
  output logic                           adv_o,
  output logic                           load_o,
  output ifp_pkg::out_beat_t             result_o
);
  import ifp_pkg::*;

  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhType  = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;
  localparam logic [1:0] PhJudge = 2'd3;

  logic [7:0]        sync_q, type_q;
  logic [1:0]        phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        check_q, check_d;
  logic [7:0]        payload_q [DataLen];
  logic              pl_we;
  logic [DataIdxW-1:0] pl_idx;
  logic              emit;
  logic [7:0]        b;

  assign b         = beat_i.rx_byte;
  assign count_inc = count_q + CountW'(1);
  assign pl_idx    = DataIdxW'(count_q - CountW'(HdrLen));

  // header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncByteRst;
      type_q <= TypeByteRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxSync) begin
        sync_q <= cfg_data_i;
      end else if (cfg_index_i == CfgIdxType) begin
        type_q <= cfg_data_i;
      end
    end
  end

  // frame is good when the checksum matches and the consumer is free
  assign emit = (phase_q == PhJudge) && (check_q == sum_q) && !beat_i.result_pending;

  // hold the byte only when a result has nowhere to go
  assign adv_o  = beat_valid_i && (!emit || out_free_i);
  assign load_o = adv_o && emit;

  // next state of one byte step
  always_comb begin
    phase_d = PhHunt;
    count_d = '0;
    sum_d   = sum_q;
    check_d = check_q;
    pl_we   = 1'b0;
    case (phase_q)
      PhHunt: begin
        if (b == sync_q) begin
          phase_d = PhType;
          count_d = CountW'(1);
          sum_d   = b;
        end
      end
      PhType: begin
        if (b == type_q) begin
          phase_d = PhData;
          count_d = CountW'(HdrLen);
          sum_d   = sum_q + b;
        end
      end
      PhData: begin
        if (count_q < CountW'(FrameLen - 1)) begin
          pl_we = 1'b1;
          sum_d = sum_q + b;
        end else begin
          check_d = b;
        end
        count_d = count_inc;
        phase_d = (count_inc >= CountW'(FrameLen)) ? PhJudge : PhData;
      end
      default: begin
        // judging byte: always back to the hunt
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      count_q <= '0;
      sum_q   <= '0;
      check_q <= '0;
    end else if (adv_o) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      check_q <= check_d;
    end
  end

  // data bytes, every one rewritten before a frame is judged
  always_ff @(posedge clk_i) begin
    if (adv_o && pl_we) begin
      payload_q[pl_idx] <= b;
    end
  end

  // little-endian words
  assign result_o.roll_code  = {payload_q[1], payload_q[0]};
  assign result_o.pitch_code = {payload_q[3], payload_q[2]};
  assign result_o.yaw_code   = {payload_q[5], payload_q[4]};
  assign result_o.extra_word = {payload_q[7], payload_q[6]};

endmodule

// ===== hdl/ifp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ifp_out_stage
// Result register: holds a decoded frame until the consumer takes the beat.
// ----------------------------------------------------------------------------
module ifp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ifp_pkg::out_beat_t result_i,
  output logic               out_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ifp_pkg::out_beat_t out_data_o
);
  import ifp_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t data_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hdl/imu_angle_frame_parser.sv =====
// ----------------------------------------------------------------------------
// imu_angle_frame_parser
// Byte-stream parser for 11-byte IMU angle frames with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and returns roll, pitch and yaw codes plus
// the fourth data word for each good frame (degrees = code * 180 / 32768). A
// byte goes through an input register and the parser step into the result
// register; throughput is one byte per cycle, and the input stalls only while
// a new result waits behind an untaken one in the result register. Sync and
// type bytes are written over the configuration port, which is always ready.
module imu_angle_frame_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ifp_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ifp_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ifp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ifp_pkg::CfgDataW-1:0] cfg_data_i
);
  import ifp_pkg::*;

  logic      beat_valid, adv, load, out_free;
  in_beat_t  beat;
  out_beat_t result;

  assign cfg_ready_o = 1'b1;

  // input register
  ifp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .adv_i       (adv),
    .beat_valid_o(beat_valid),
    .beat_o      (beat)
  );

  // frame state machine
  ifp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .beat_valid_i(beat_valid),
    .beat_i      (beat),
    .out_free_i  (out_free),
    .adv_o       (adv),
    .load_o      (load),
    .result_o    (result)
  );

  // result register
  ifp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .result_i   (result),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/ifp_checker.sv =====
// ----------------------------------------------------------------------------
// ifp_checker
// Port-level checks of the angle frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ifp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input ifp_pkg::out_beat_t           out_data_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // input backpressure only comes from a blocked result register
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a fresh result follows an accepted input beat
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a judging beat");

endmodule

bind imu_angle_frame_parser ifp_checker u_ifp_checker (.*);

// ===== bench/imu_angle_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_tb
// Self-checking bench for the IMU angle frame parser.
// ----------------------------------------------------------------------------
// Streams serial bytes into the parser: header rejects, extreme field values,
// a pending-result reject, then random frames, broken frames and line noise
// under several sync/type settings and idle patterns. A behavioral parser
// tracks every accepted byte and queues the angle beats it should produce;
// each result beat is checked field by field against the oldest entry.
module imu_angle_frame_parser_tb;
  import ifp_pkg::*;

  localparam int unsigned Latency        = 2;
  localparam int unsigned DrainCycles    = Latency + 4;
  localparam int unsigned CycleLimit     = 200_000;
  localparam int unsigned BytesPerConfig = 270;

  typedef enum logic [1:0] {PhHunt, PhType, PhData, PhJudge} parse_phase_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_beat_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // register copies and parser state of the behavioral parser
  logic [7:0]   cur_sync   = SyncByteRst;
  logic [7:0]   cur_type   = TypeByteRst;
  parse_phase_e phase      = PhHunt;
  int unsigned  frame_pos  = 0;
  logic [7:0]   frame_data [DataLen];
  logic [7:0]   rx_check   = '0;
  logic [7:0]   run_sum    = '0;

  out_beat_t    angles_expected_q [$];
  out_beat_t    angles_want;
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent     = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  stall_pct      = 0;

  imu_angle_frame_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("imu_angle_frame_parser test failed");
      $finish;
    end
  end

  // random back-pressure on the result side
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // back to the hunt with the frame buffer cleared
  function automatic void clear_frame();
    phase      = PhHunt;
    frame_pos  = 0;
    frame_data = '{default: '0};
    rx_check   = '0;
    run_sum    = '0;
  endfunction

  // advance the behavioral parser by one accepted byte
  function automatic void parse_rx_byte(in_beat_t beat);
    out_beat_t angles;
    logic [7:0] b;
    b = beat.rx_byte;
    if (phase == PhHunt && b == cur_sync) begin
      phase     = PhType;
      frame_pos = 1;
      run_sum   = b;
    end else if (phase == PhType && b == cur_type) begin
      phase     = PhData;
      frame_pos = 2;
      run_sum   = run_sum + b;
    end else if (phase == PhData) begin
      if (frame_pos < FrameLen - 1) begin
        frame_data[DataIdxW'(frame_pos - HdrLen)] = b;
        run_sum = run_sum + b;
      end else begin
        rx_check = b;
      end
      frame_pos++;
      if (frame_pos >= FrameLen) phase = PhJudge;
    end else if (phase == PhJudge) begin
      // judging byte: value ignored, result only on good sum and free consumer
      if (rx_check == run_sum && !beat.result_pending) begin
        angles.roll_code  = {frame_data[1], frame_data[0]};
        angles.pitch_code = {frame_data[3], frame_data[2]};
        angles.yaw_code   = {frame_data[5], frame_data[4]};
        angles.extra_word = {frame_data[7], frame_data[6]};
        angles_expected_q.push_back(angles);
      end
      clear_frame();
    end else begin
      clear_frame();
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result beat with the oldest queued angles
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angles_expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %h", $time,
                 out_data_o);
        mismatch_count++;
      end else begin
        angles_want = angles_expected_q.pop_front();
        check_field("roll_code", angles_want.roll_code, out_data_o.roll_code);
        check_field("pitch_code", angles_want.pitch_code, out_data_o.pitch_code);
        check_field("yaw_code", angles_want.yaw_code, out_data_o.yaw_code);
        check_field("extra_word", angles_want.extra_word, out_data_o.extra_word);
      end
    end
  end

  // send one serial byte, idling first at the current rate
  task automatic send_byte(input logic [7:0] b, input logic pend);
    in_beat_t beat;
    beat.rx_byte        = b;
    beat.result_pending = pend;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    parse_rx_byte(beat);
    bytes_sent++;
  endtask

  // hold off input until every queued result has arrived and the pipe is empty
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (angles_expected_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write beat; valid stays high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgIdxSync) cur_sync = val;
    else if (idx == CfgIdxType) cur_type = val;
  endtask

  // both header registers plus an ignored write to an unused index
  task automatic load_regs(input logic [7:0] sync_v, input logic [7:0] type_v);
    write_reg(CfgIdxW'($urandom_range(255, 2)), 8'($urandom_range(255)));
    write_reg(CfgIdxSync, sync_v);
    write_reg(CfgIdxType, type_v);
    cfg_valid_i <= 1'b0;
  endtask

  // full frame with the current header; data byte i sits at d[8*i +: 8]
  task automatic send_frame(input logic [63:0] d, input bit bad_sum,
                            input bit pend_on_judge);
    logic [7:0] sum;
    sum = cur_sync + cur_type;
    for (int i = 0; i < DataLen; i++) sum = sum + d[8*i +: 8];
    if (bad_sum) sum = sum + 8'($urandom_range(255, 1));
    send_byte(cur_sync, 1'($urandom_range(1)));
    send_byte(cur_type, 1'($urandom_range(1)));
    for (int i = 0; i < DataLen; i++) send_byte(d[8*i +: 8], 1'($urandom_range(1)));
    send_byte(sum, 1'($urandom_range(1)));
    send_byte(8'($urandom_range(255)), pend_on_judge);
  endtask

  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one random chunk: mostly whole frames, some broken headers and noise
  task automatic send_random_chunk();
    int unsigned pick;
    int unsigned n;
    logic [63:0] d;
    pick = $urandom_range(99);
    if (pick < 70) begin
      for (int i = 0; i < DataLen; i++) d[8*i +: 8] = pick_data_byte();
      send_frame(d, $urandom_range(99) < 15, $urandom_range(99) < 15);
    end else if (pick < 80) begin
      // truncated frame, the following bytes land in its data field
      n = $urandom_range(DataLen);
      send_byte(cur_sync, 1'($urandom_range(1)));
      send_byte(cur_type, 1'($urandom_range(1)));
      repeat (n) send_byte(pick_data_byte(), 1'($urandom_range(1)));
    end else if (pick < 90) begin
      send_byte(cur_sync, 1'($urandom_range(1)));
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    if ($urandom_range(59) == 0) wait_results_drained();
  endtask

  // noise in the hunt, a repeated sync rejected as type, a stray type byte
  task automatic test_header_rejects();
    send_byte(8'h00, 1'b1);
    send_byte(cur_sync, 1'b0);
    send_byte(cur_sync, 1'b1);
    send_byte(cur_type, 1'b0);
  endtask

  // signed min, max, -1 and 0 across the words, then the inverted frame while a result pends
  task automatic test_field_extremes();
    logic [63:0] d;
    d = {8'h00, 8'h00, 8'hff, 8'hff, 8'h7f, 8'hff, 8'h80, 8'h00};
    send_frame(d, 1'b0, 1'b0);
    send_frame(~d, 1'b0, 1'b1);
  endtask

  // random traffic under each header setting and idle pattern
  task automatic test_register_sweep();
    logic [7:0] same_v;
    int unsigned stop_at;
    for (int s = 0; s < 5; s++) begin
      wait_results_drained();
      same_v = 8'($urandom_range(255));
      case (s)
        0: begin
          load_regs(8'h00, 8'hff);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          load_regs(8'hff, 8'h00);
          send_idle_pct = 82;
          stall_pct     = 0;
        end
        2: begin
          load_regs(8'($urandom_range(255)), 8'($urandom_range(255)));
          send_idle_pct = 0;
          stall_pct     = 82;
        end
        3: begin
          // sync and type equal
          load_regs(same_v, same_v);
          send_idle_pct = 33;
          stall_pct     = 33;
        end
        default: begin
          load_regs(SyncByteRst, TypeByteRst);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      stop_at = bytes_sent + BytesPerConfig;
      while (bytes_sent < stop_at) send_random_chunk();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_header_rejects();
    test_field_extremes();
    test_register_sweep();
    wait_results_drained();
    if (mismatch_count == 0 && angles_expected_q.size() == 0) begin
      $display("imu_angle_frame_parser test passed");
    end else begin
      $display("imu_angle_frame_parser test failed");
    end
    $finish;
  end

endmodule

// ===== imu_angle_frame_parser.f =====
hdl/ifp_pkg.sv
hdl/ifp_in_stage.sv
hdl/ifp_parser.sv
hdl/ifp_out_stage.sv
hdl/imu_angle_frame_parser.sv
hdl/ifp_checker.sv
bench/imu_angle_frame_parser_tb.sv
